@@ rtl/mmdp_pkg.sv @@
`default_nettype none
package mmdp_pkg;

  // Matrix dimensions
  localparam int unsigned MAX_ROWS  = 64;
  localparam int unsigned MAX_INNER = 64;
  localparam int unsigned MAX_COLS  = 64;

  // Store geometry
  localparam int unsigned LEFT_DEPTH  = MAX_ROWS * MAX_INNER;
  localparam int unsigned RIGHT_DEPTH = MAX_INNER * MAX_COLS;
  localparam int unsigned LEFT_AW     = $clog2(LEFT_DEPTH);
  localparam int unsigned RIGHT_AW    = $clog2(RIGHT_DEPTH);

  // Field widths
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned KCFG_W = 7;
  localparam int unsigned PROD_W = 2 * VAL_W;
  localparam int unsigned SUM_W  = 38;

  // Inner counter holds 0..MAX_INNER
  localparam int unsigned KCNT_W = $clog2(MAX_INNER + 1);

  localparam logic [KCFG_W-1:0] K_USED_RST = KCFG_W'(64);

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD_LEFT  = 2'd0,
    ACT_LOAD_RIGHT = 2'd1,
    ACT_COMPUTE    = 2'd2,
    ACT_NONE       = 2'd3
  } action_e;

endpackage
`default_nettype wire

@@ rtl/mmdp_ram.sv @@
`default_nettype none
// Single-port RAM, registered read
module mmdp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ rtl/matrix_multiply_dot_product.sv @@
`default_nettype none
// Channel  | Handshake                  | Payload
// ---------+----------------------------+-----------------------------------
// input    | in_valid_i / in_ready_o    | action_i, row_i, col_i, value_i
// result   | out_valid_o / out_ready_i  | out_row_o, out_col_o, sum_o
// config   | cfg_valid_i / cfg_ready_o  | cfg_data_i (k_used)
//
// A compute walks k_used inner terms (capped at MAX_INNER),
// one read of each single-port store and one multiply-accumulate per cycle.
// Its result is registered once the read, product and accumulate registers have drained;
// the input is held off until then and reopens as the result is registered.
// A result held in the output register stalls the next compute in its last cycle.
// Reset clears control and sets k_used to 64; the stores are not cleared.
module matrix_multiply_dot_product (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [mmdp_pkg::ACT_W-1:0]          action_i,
  input  wire logic [mmdp_pkg::IDX_W-1:0]          row_i,
  input  wire logic [mmdp_pkg::IDX_W-1:0]          col_i,
  input  wire logic signed [mmdp_pkg::VAL_W-1:0]   value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic      [mmdp_pkg::IDX_W-1:0]          out_row_o,
  output logic      [mmdp_pkg::IDX_W-1:0]          out_col_o,
  output logic signed [mmdp_pkg::SUM_W-1:0]        sum_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [mmdp_pkg::KCFG_W-1:0]         cfg_data_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam int unsigned BND_W = mmdp_pkg::IDX_W + 1;

  logic [1:0]                          state_q, state_d;
  logic [mmdp_pkg::KCFG_W-1:0]         k_used_q;
  logic [mmdp_pkg::KCNT_W-1:0]         cnt_q, cnt_d;
  logic [mmdp_pkg::KCNT_W-1:0]         len_q, len_d;
  logic [mmdp_pkg::IDX_W-1:0]          row_q, col_q;
  logic                                rd_vld_q, mul_vld_q;
  logic signed [mmdp_pkg::PROD_W-1:0]  mul_q;
  logic signed [mmdp_pkg::SUM_W-1:0]   acc_q, acc_d;
  logic                                out_valid_q;
  logic [mmdp_pkg::IDX_W-1:0]          out_row_q, out_col_q;
  logic signed [mmdp_pkg::SUM_W-1:0]   sum_q;

  logic                                in_acc, issue, finish;
  logic                                row_ok, col_ok, inner_row_ok, inner_col_ok;
  logic [mmdp_pkg::KCNT_W-1:0]         k_clip;
  logic                                left_we, right_we;
  logic [mmdp_pkg::LEFT_AW-1:0]        left_addr;
  logic [mmdp_pkg::RIGHT_AW-1:0]       right_addr;
  logic signed [mmdp_pkg::VAL_W-1:0]   left_rd, right_rd;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i & in_ready_o;

  // Bounds against the store dimensions
  assign row_ok       = {1'b0, row_i} < BND_W'(mmdp_pkg::MAX_ROWS);
  assign col_ok       = {1'b0, col_i} < BND_W'(mmdp_pkg::MAX_COLS);
  assign inner_row_ok = {1'b0, row_i} < BND_W'(mmdp_pkg::MAX_INNER);
  assign inner_col_ok = {1'b0, col_i} < BND_W'(mmdp_pkg::MAX_INNER);

  assign k_clip = (k_used_q > mmdp_pkg::KCFG_W'(mmdp_pkg::MAX_INNER))
                  ? mmdp_pkg::KCNT_W'(mmdp_pkg::MAX_INNER)
                  : mmdp_pkg::KCNT_W'(k_used_q);

  // Store writes on load items
  assign left_we  = in_acc & (action_i == mmdp_pkg::ACT_LOAD_LEFT) & row_ok & inner_col_ok;
  assign right_we = in_acc & (action_i == mmdp_pkg::ACT_LOAD_RIGHT) & inner_row_ok & col_ok;

  // One port per store: load address when idle, walk address when running
  always_comb begin
    if (state_q == S_IDLE) begin
      left_addr  = mmdp_pkg::LEFT_AW'(row_i * mmdp_pkg::MAX_INNER + col_i);
      right_addr = mmdp_pkg::RIGHT_AW'(row_i * mmdp_pkg::MAX_COLS + col_i);
    end else begin
      left_addr  = mmdp_pkg::LEFT_AW'(row_q * mmdp_pkg::MAX_INNER + cnt_q);
      right_addr = mmdp_pkg::RIGHT_AW'(cnt_q * mmdp_pkg::MAX_COLS + col_q);
    end
  end

  mmdp_ram #(
    .Width (mmdp_pkg::VAL_W),
    .Depth (mmdp_pkg::LEFT_DEPTH)
  ) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (left_we),
    .addr_i  (left_addr),
    .wdata_i (value_i),
    .rdata_o (left_rd)
  );

  mmdp_ram #(
    .Width (mmdp_pkg::VAL_W),
    .Depth (mmdp_pkg::RIGHT_DEPTH)
  ) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (right_we),
    .addr_i  (right_addr),
    .wdata_i (value_i),
    .rdata_o (right_rd)
  );

  assign issue  = (state_q == S_RUN) & (cnt_q < len_q);
  assign finish = (state_q == S_DONE) & (~out_valid_q | out_ready_i);

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    acc_d   = acc_q;
    if (mul_vld_q) begin
      acc_d = acc_q + mmdp_pkg::SUM_W'(mul_q);
    end
    if (issue) begin
      cnt_d = cnt_q + 1'b1;
    end
    case (state_q)
      S_IDLE: begin
        if (in_acc && action_i == mmdp_pkg::ACT_COMPUTE) begin
          state_d = S_RUN;
          cnt_d   = '0;
          acc_d   = '0;
          len_d   = (row_ok && col_ok) ? k_clip : '0;
        end
      end
      S_RUN: begin
        if (!issue && !rd_vld_q && !mul_vld_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (finish) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_used_q    <= mmdp_pkg::K_USED_RST;
      rd_vld_q    <= 1'b0;
      mul_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      len_q       <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      len_q     <= len_d;
      rd_vld_q  <= issue;
      mul_vld_q <= rd_vld_q;
      if (cfg_valid_i) begin
        k_used_q <= cfg_data_i;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath: product register, accumulator, item latch, result register
  always_ff @(posedge clk_i) begin
    mul_q <= left_rd * right_rd;
    acc_q <= acc_d;
    if (in_acc) begin
      row_q <= row_i;
      col_q <= col_i;
    end
    if (finish) begin
      out_row_q <= row_q;
      out_col_q <= col_q;
      sum_q     <= acc_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign sum_o       = sum_q;

endmodule
`default_nettype wire

@@ test/matrix_multiply_dot_product_tb.sv @@
`timescale 1ns / 100ps
module matrix_multiply_dot_product_tb;

  // One product element as the block returns it
  typedef struct packed {
    logic [mmdp_pkg::IDX_W-1:0]        row;
    logic [mmdp_pkg::IDX_W-1:0]        col;
    logic signed [mmdp_pkg::SUM_W-1:0] sum;
  } dot_t;

  // Directed script: either an item or a k_used write (k taken from value)
  typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_e;

  typedef struct packed {
    step_kind_e                        kind;
    mmdp_pkg::action_e                 act;
    logic [mmdp_pkg::IDX_W-1:0]        row;
    logic [mmdp_pkg::IDX_W-1:0]        col;
    logic signed [mmdp_pkg::VAL_W-1:0] value;
    logic                              known;
    logic signed [mmdp_pkg::SUM_W-1:0] sum;
  } step_t;

  localparam int N_STEPS = 23;
  localparam step_t SCRIPT [N_STEPS] = '{
    // single-term sums over the value extremes
    '{STEP_CFG,  mmdp_pkg::ACT_NONE,       6'd0,  6'd0,  16'sd1,      1'b0, 38'sd0},
    '{STEP_ITEM, mmdp_pkg::ACT_LOAD_LEFT,  6'd0,  6'd0,  16'sh8000,   1'b0, 38'sd0},
    '{STEP_ITEM, mmdp_pkg::ACT_LOAD_RIGHT, 6'd0,  6'd0,  16'sh8000,   1'b0, 38'sd0},
    '{STEP_ITEM, mmdp_pkg::ACT_COMPUTE,    6'd0,  6'd0,  16'sd0,      1'b1, 38'sd1073741824},
    '{STEP_ITEM, mmdp_pkg::ACT_LOAD_LEFT,  6'd0,  6'd0,  16'sh7FFF,   1'b0, 38'sd0},
    '{STEP_ITEM, mmdp_pkg::ACT_COMPUTE,    6'd0,  6'd0,  16'sd0,      1'b1, -38'sd1073709056},
    '{STEP_ITEM, mmdp_pkg::ACT_LOAD_RIGHT, 6'd0,  6'd0,  16'sh7FFF,   1'b0, 38'sd0},
    '{STEP_ITEM, mmdp_pkg::ACT_COMPUTE,    6'd0,  6'd0,  16'sd0,      1'b1, 38'sd1073676289},
    // empty sum
    '{STEP_CFG,  mmdp_pkg::ACT_NONE,       6'd0,  6'd0,  16'sd0,      1'b0, 38'sd0},
    '{STEP_ITEM, mmdp_pkg::ACT_COMPUTE,    6'd0,  6'd0,  -16'sd1,     1'b1, 38'sd0},
    // two terms at the top corner, unused action in between
    '{STEP_CFG,  mmdp_pkg::ACT_NONE,       6'd0,  6'd0,  16'sd2,      1'b0, 38'sd0},
    '{STEP_ITEM, mmdp_pkg::ACT_LOAD_LEFT,  6'd63, 6'd0,  16'sd12345,  1'b0, 38'sd0},
    '{STEP_ITEM, mmdp_pkg::ACT_LOAD_LEFT,  6'd63, 6'd1,  -16'sd1,     1'b0, 38'sd0},
    '{STEP_ITEM, mmdp_pkg::ACT_LOAD_RIGHT, 6'd0,  6'd63, 16'sd2,      1'b0, 38'sd0},
    '{STEP_ITEM, mmdp_pkg::ACT_LOAD_RIGHT, 6'd1,  6'd63, 16'sd32767,  1'b0, 38'sd0},
    '{STEP_ITEM, mmdp_pkg::ACT_COMPUTE,    6'd63, 6'd63, 16'sd0,      1'b1, -38'sd8077},
    '{STEP_ITEM, mmdp_pkg::ACT_NONE,       6'd63, 6'd63, -16'sd1,     1'b0, 38'sd0},
    '{STEP_ITEM, mmdp_pkg::ACT_COMPUTE,    6'd63, 6'd63, 16'sd0,      1'b1, -38'sd8077},
    '{STEP_ITEM, mmdp_pkg::ACT_LOAD_RIGHT, 6'd1,  6'd63, 16'sh8000,   1'b0, 38'sd0},
    '{STEP_ITEM, mmdp_pkg::ACT_COMPUTE,    6'd63, 6'd63, 16'sd0,      1'b1, 38'sd57458},
    '{STEP_ITEM, mmdp_pkg::ACT_LOAD_LEFT,  6'd0,  6'd1,  -16'sd12345, 1'b0, 38'sd0},
    '{STEP_ITEM, mmdp_pkg::ACT_COMPUTE,    6'd0,  6'd63, 16'sd0,      1'b0, 38'sd0},
    '{STEP_ITEM, mmdp_pkg::ACT_COMPUTE,    6'd63, 6'd0,  16'sd0,      1'b0, 38'sd0}
  };

  // k_used per random phase; one more random setting follows
  localparam int N_PHASES = 11;
  localparam logic [mmdp_pkg::KCFG_W-1:0] PHASE_K [N_PHASES] = '{
    7'd1, 7'd2, 7'd5, 7'd127, 7'd3, 7'd0, 7'd16, 7'd64, 7'd9, 7'd1, 7'd33
  };
  localparam int PHASE_ITEMS = 115;

  // DUT inputs, known from time zero
  logic                              clk_i       = 1'b0;
  logic                              rst_ni      = 1'b0;
  logic                              in_valid_i  = 1'b0;
  logic [mmdp_pkg::ACT_W-1:0]        action_i    = '0;
  logic [mmdp_pkg::IDX_W-1:0]        row_i       = '0;
  logic [mmdp_pkg::IDX_W-1:0]        col_i       = '0;
  logic signed [mmdp_pkg::VAL_W-1:0] value_i     = '0;
  logic                              out_ready_i = 1'b0;
  logic                              cfg_valid_i = 1'b0;
  logic [mmdp_pkg::KCFG_W-1:0]       cfg_data_i  = '0;

  logic                              in_ready_o;
  logic                              out_valid_o;
  logic [mmdp_pkg::IDX_W-1:0]        out_row_o;
  logic [mmdp_pkg::IDX_W-1:0]        out_col_o;
  logic signed [mmdp_pkg::SUM_W-1:0] sum_o;
  logic                              cfg_ready_o;

  // Shadow copy of the stores and the inner length
  logic signed [mmdp_pkg::VAL_W-1:0] left_mem  [mmdp_pkg::LEFT_DEPTH];
  logic signed [mmdp_pkg::VAL_W-1:0] right_mem [mmdp_pkg::RIGHT_DEPTH];
  bit                                left_set  [mmdp_pkg::LEFT_DEPTH];
  bit                                right_set [mmdp_pkg::RIGHT_DEPTH];
  logic [mmdp_pkg::KCFG_W-1:0]       inner_len = mmdp_pkg::K_USED_RST;

  dot_t pending_dots [$];
  dot_t want_dot;
  int   err_count  = 0;
  int   items_sent = 0;
  int   burst_left = 0;
  int   rx_hold    = 0;
  bit   rx_open    = 1'b0;

  matrix_multiply_dot_product u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .sum_o       (sum_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Inner length actually walked: k_used capped at the store depth
  function automatic int inner_span();
    return (inner_len > mmdp_pkg::MAX_INNER) ? mmdp_pkg::MAX_INNER : int'(inner_len);
  endfunction

  // Exact dot product of left row r and right column c
  function automatic logic signed [mmdp_pkg::SUM_W-1:0] dot_sum(
      logic [mmdp_pkg::IDX_W-1:0] r, logic [mmdp_pkg::IDX_W-1:0] c);
    longint acc;
    acc = 0;
    for (int i = 0; i < inner_span(); i++)
      acc += longint'(int'(left_mem[r*mmdp_pkg::MAX_INNER + i]) *
                      int'(right_mem[i*mmdp_pkg::MAX_COLS + c]));
    return acc[mmdp_pkg::SUM_W-1:0];
  endfunction

  // Element values with the extremes weighted in
  function automatic logic signed [mmdp_pkg::VAL_W-1:0] rand_elem();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return -16'sd1;
      3:       return 16'sd0;
      default: return mmdp_pkg::VAL_W'($urandom);
    endcase
  endfunction

  // Drive one item in sender bursts; update the shadow state once accepted
  task automatic send_item(input mmdp_pkg::action_e act,
                           input logic [mmdp_pkg::IDX_W-1:0] r,
                           input logic [mmdp_pkg::IDX_W-1:0] c,
                           input logic signed [mmdp_pkg::VAL_W-1:0] v,
                           input bit known = 1'b0,
                           input logic signed [mmdp_pkg::SUM_W-1:0] known_sum = '0);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    action_i   <= act;
    row_i      <= r;
    col_i      <= c;
    value_i    <= v;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);

    case (act)
      mmdp_pkg::ACT_LOAD_LEFT: begin
        left_mem[r*mmdp_pkg::MAX_INNER + c] = v;
        left_set[r*mmdp_pkg::MAX_INNER + c] = 1'b1;
      end
      mmdp_pkg::ACT_LOAD_RIGHT: begin
        right_mem[r*mmdp_pkg::MAX_COLS + c] = v;
        right_set[r*mmdp_pkg::MAX_COLS + c] = 1'b1;
      end
      mmdp_pkg::ACT_COMPUTE:
        pending_dots.push_back(dot_t'{r, c, known ? known_sum : dot_sum(r, c)});
      default: ;
    endcase
    if (act != mmdp_pkg::ACT_NONE) items_sent++;
  endtask

  // k_used write with the block drained
  task automatic set_inner_len(input logic [mmdp_pkg::KCFG_W-1:0] k);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_dots.size() != 0) @(posedge clk_i);
    repeat (mmdp_pkg::MAX_INNER + 8) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= k;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    inner_len = k;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Load whatever operands are still missing, then ask for the product
  task automatic compute_at(input logic [mmdp_pkg::IDX_W-1:0] r,
                            input logic [mmdp_pkg::IDX_W-1:0] c);
    for (int i = 0; i < inner_span(); i++) begin
      if (!left_set[r*mmdp_pkg::MAX_INNER + i])
        send_item(mmdp_pkg::ACT_LOAD_LEFT, r, mmdp_pkg::IDX_W'(i), rand_elem());
      if (!right_set[i*mmdp_pkg::MAX_COLS + c])
        send_item(mmdp_pkg::ACT_LOAD_RIGHT, mmdp_pkg::IDX_W'(i), c, rand_elem());
    end
    send_item(mmdp_pkg::ACT_COMPUTE, r, c, mmdp_pkg::VAL_W'($urandom));
  endtask

  // Full row and column of one constant each: reaches the sum extremes
  task automatic extreme_dot(input logic [mmdp_pkg::IDX_W-1:0] r,
                             input logic [mmdp_pkg::IDX_W-1:0] c,
                             input logic signed [mmdp_pkg::VAL_W-1:0] a,
                             input logic signed [mmdp_pkg::VAL_W-1:0] b,
                             input logic signed [mmdp_pkg::SUM_W-1:0] want);
    for (int i = 0; i < inner_span(); i++) begin
      send_item(mmdp_pkg::ACT_LOAD_LEFT, r, mmdp_pkg::IDX_W'(i), a);
      send_item(mmdp_pkg::ACT_LOAD_RIGHT, mmdp_pkg::IDX_W'(i), c, b);
    end
    send_item(mmdp_pkg::ACT_COMPUTE, r, c, 16'sd0, 1'b1, want);
  endtask

  // Random traffic at one k_used: mostly loads feeding computes, some noise
  task automatic run_phase(input logic [mmdp_pkg::KCFG_W-1:0] k);
    int stop;
    int sel;
    logic [mmdp_pkg::IDX_W-1:0] r;
    logic [mmdp_pkg::IDX_W-1:0] c;
    set_inner_len(k);
    stop = items_sent + PHASE_ITEMS;
    while (items_sent < stop) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        // long sums stay on a few rows and columns so fills get reused
        if (inner_span() > 16) begin
          r = mmdp_pkg::IDX_W'(21 * $urandom_range(0, 3));
          c = mmdp_pkg::IDX_W'(21 * $urandom_range(0, 3));
        end else begin
          r = mmdp_pkg::IDX_W'($urandom);
          c = mmdp_pkg::IDX_W'($urandom);
        end
        compute_at(r, c);
      end else if (sel < 92) begin
        send_item($urandom_range(0, 1) ? mmdp_pkg::ACT_LOAD_RIGHT
                                       : mmdp_pkg::ACT_LOAD_LEFT,
                  mmdp_pkg::IDX_W'($urandom), mmdp_pkg::IDX_W'($urandom), rand_elem());
      end else begin
        send_item(mmdp_pkg::ACT_NONE, mmdp_pkg::IDX_W'($urandom),
                  mmdp_pkg::IDX_W'($urandom), mmdp_pkg::VAL_W'($urandom));
      end
    end
  endtask

  // Result side: ready in open and stalled stretches of random length
  always @(negedge clk_i) begin
    if (rx_hold == 0) begin
      rx_open = ($urandom_range(0, 3) != 0);
      rx_hold = rx_open ? $urandom_range(1, 40) : $urandom_range(1, 12);
    end else begin
      rx_hold--;
    end
    out_ready_i <= rx_open;
  end

  // Compare each returned item with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_dots.size() == 0) begin
        $error("unexpected result: row %0d col %0d sum %0d", out_row_o, out_col_o, sum_o);
        err_count++;
      end else begin
        want_dot = pending_dots.pop_front();
        if (out_row_o !== want_dot.row) begin
          $error("out_row: expected %0d, got %0d", want_dot.row, out_row_o);
          err_count++;
        end
        if (out_col_o !== want_dot.col) begin
          $error("out_col: expected %0d, got %0d", want_dot.col, out_col_o);
          err_count++;
        end
        if (sum_o !== want_dot.sum) begin
          $error("sum: expected %0d, got %0d", want_dot.sum, sum_o);
          err_count++;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // k_used still at its reset value: largest and smallest possible sums
    extreme_dot(6'd0, 6'd0, 16'sh8000, 16'sh8000, 38'sd68719476736);
    extreme_dot(6'd63, 6'd63, 16'sh7FFF, 16'sh8000, -38'sd68717379584);

    for (int i = 0; i < N_STEPS; i++) begin
      if (SCRIPT[i].kind == STEP_CFG)
        set_inner_len(mmdp_pkg::KCFG_W'(SCRIPT[i].value));
      else
        send_item(SCRIPT[i].act, SCRIPT[i].row, SCRIPT[i].col, SCRIPT[i].value,
                  SCRIPT[i].known, SCRIPT[i].sum);
    end

    for (int p = 0; p < N_PHASES; p++)
      run_phase(PHASE_K[p]);
    run_phase(mmdp_pkg::KCFG_W'($urandom_range(0, 127)));

    // drain
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_dots.size() != 0) @(posedge clk_i);
    repeat (mmdp_pkg::MAX_INNER + 8) @(posedge clk_i);
    if (err_count == 0)
      $display("** matrix_multiply_dot_product: PASSED **");
    else
      $display("** matrix_multiply_dot_product: FAILED **");
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("** matrix_multiply_dot_product: FAILED **");
    $finish;
  end

endmodule
